// File: rtl/assert_macros.svh
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define OPT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold.
`define OPT_ASSERT_NEVER(name, cond, msg) \
  `OPT_ASSERT(name, !(cond), msg)

`endif

// File: rtl/opt_pkg.sv
// Shared types and constants of the one-shot/periodic timer.
package opt_pkg;

  localparam int unsigned OpWidth       = 3;
  localparam int unsigned DurationWidth = 32;
  localparam int unsigned ElapsedWidth  = 32;
  localparam int unsigned FracIntBits   = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_TICK        = 3'd0,
    OP_START       = 3'd1,
    OP_RESET       = 3'd2,
    OP_RESTART     = 3'd3,
    OP_RESTART_DUR = 3'd4,
    OP_EXTEND      = 3'd5
  } op_e;

  typedef struct packed {
    logic capture;
    logic apply;
    logic div_align;
    logic align_commit;
    logic div_frac;
    logic load_out;
  } opt_cmd_t;

  typedef struct packed {
    logic need_align;
    logic need_frac;
    logic div_done;
  } opt_sts_t;

endpackage

// File: rtl/opt_ctrl.sv
// Sequencing state machine of the timer: request intake, division passes, result hand-off.
module opt_ctrl
  import opt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  opt_sts_t sts_i,
  output opt_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_ALIGN = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_FRAC  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.need_align) begin
          cmd_o.div_align = 1'b1;
          state_d         = ST_ALIGN;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = ST_EVAL;
        end
      end
      ST_ALIGN: begin
        if (sts_i.div_done) begin
          cmd_o.align_commit = 1'b1;
          state_d            = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.need_frac) begin
          cmd_o.div_frac = 1'b1;
          state_d        = ST_FRAC;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_FRAC: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/opt_dp.sv
// Timer datapath: time and period registers, bit-serial divider, result registers.
module opt_dp
  import opt_pkg::*;
#(
  parameter int unsigned TimeWidth    = 32,
  parameter int unsigned FractionBits = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  opt_cmd_t                            cmd_i,
  output opt_sts_t                            sts_o,
  input  logic [OpWidth-1:0]                  op_i,
  input  logic [DurationWidth-1:0]            duration_i,
  input  logic                                clamp_i,
  output logic                                running_o,
  output logic                                expired_o,
  output logic                                active_o,
  output logic [ElapsedWidth-1:0]             elapsed_o,
  output logic [FracIntBits+FractionBits-1:0] fraction_o
);

  localparam int unsigned QuotWidth = FracIntBits + FractionBits;
  localparam int unsigned CntWidth  = $clog2(TimeWidth + FractionBits + 1);
  localparam logic [CntWidth-1:0] AlignSteps = CntWidth'(TimeWidth);
  localparam logic [CntWidth-1:0] FracSteps  = CntWidth'(TimeWidth + FractionBits);

  op_e                    op_q;
  logic [TimeWidth-1:0]   dur_q;
  logic                   clamp_q;

  logic [TimeWidth-1:0]   now_q, now_d;
  logic [TimeWidth-1:0]   start_q, start_d;
  logic [TimeWidth-1:0]   period_q, period_d;
  logic                   running_q, running_d;

  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [TimeWidth-1:0]   rem_q, rem_d;
  logic [TimeWidth-1:0]   dvd_q, dvd_d;
  logic [QuotWidth-1:0]   quot_q, quot_d;
  logic                   sat_q, sat_d;

  logic [TimeWidth-1:0]   el;
  logic                   period_zero;
  logic                   expired_w;
  logic [TimeWidth:0]     shifted;
  logic [TimeWidth:0]     diff;
  logic                   qbit;
  logic [QuotWidth-1:0]   frac_w;

  assign el          = now_q - start_q;
  assign period_zero = (period_q == '0);
  assign expired_w   = running_q && (period_zero || (el >= period_q));

  assign sts_o.need_align = running_q && !period_zero &&
                            ((op_q == OP_RESTART) || (op_q == OP_RESTART_DUR));
  assign sts_o.need_frac  = running_q && !period_zero && !(clamp_q && expired_w);
  assign sts_o.div_done   = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= op_e'(op_i);
      dur_q   <= TimeWidth'(duration_i);
      clamp_q <= clamp_i;
    end
  end

  always_comb begin
    now_d     = now_q;
    start_d   = start_q;
    period_d  = period_q;
    running_d = running_q;
    if (cmd_i.apply) begin
      case (op_q)
        OP_TICK: begin
          now_d = now_q + TimeWidth'(1);
        end
        OP_START: begin
          start_d   = now_q;
          period_d  = dur_q;
          running_d = 1'b1;
        end
        OP_RESET: begin
          start_d   = '0;
          period_d  = '0;
          running_d = 1'b0;
        end
        OP_RESTART, OP_RESTART_DUR: begin
          start_d   = now_q;
          period_d  = (op_q == OP_RESTART_DUR) ? dur_q : '0;
          running_d = 1'b1;
        end
        OP_EXTEND: begin
          if (running_q) begin
            period_d = period_q + dur_q;
          end
        end
        default: begin
          now_d = now_q;
        end
      endcase
    end else if (cmd_i.align_commit) begin
      start_d = now_q - rem_q;
      if (op_q == OP_RESTART_DUR) begin
        period_d = dur_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q     <= '0;
      start_q   <= '0;
      period_q  <= '0;
      running_q <= 1'b0;
    end else begin
      now_q     <= now_d;
      start_q   <= start_d;
      period_q  <= period_d;
      running_q <= running_d;
    end
  end

  // Restoring division, one bit per cycle: el mod period, or (el << FractionBits) / period.
  assign shifted = {rem_q, dvd_q[TimeWidth-1]};
  assign diff    = shifted - {1'b0, period_q};
  assign qbit    = !diff[TimeWidth];

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    sat_d  = sat_q;
    if (cmd_i.div_align || cmd_i.div_frac) begin
      cnt_d  = cmd_i.div_frac ? FracSteps : AlignSteps;
      rem_d  = '0;
      dvd_d  = el;
      quot_d = '0;
      sat_d  = 1'b0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntWidth'(1);
      rem_d  = qbit ? diff[TimeWidth-1:0] : shifted[TimeWidth-1:0];
      dvd_d  = {dvd_q[TimeWidth-2:0], 1'b0};
      quot_d = {quot_q[QuotWidth-2:0], qbit};
      sat_d  = sat_q | quot_q[QuotWidth-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  always_comb begin
    if (!running_q || period_zero) begin
      frac_w = '0;
    end else if (clamp_q && expired_w) begin
      frac_w = QuotWidth'(1) << FractionBits;
    end else if (sat_q) begin
      frac_w = '1;
    end else begin
      frac_w = quot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      running_o  <= running_q;
      expired_o  <= expired_w;
      active_o   <= running_q && !expired_w;
      elapsed_o  <= running_q ? ElapsedWidth'(el) : '0;
      fraction_o <= frac_w;
    end
  end

endmodule

// File: rtl/oneshot_periodic_timer.sv
// Top level of the one-shot/periodic timer with phase-aligned restart.
//
// Input channel (in_valid_i/in_ready_o) carries one request: op_i, duration_i,
// clamp_i. Op 0 advances the microsecond counter; ops 1..5 start, reset,
// restart, restart with a new duration and extend the timer; codes 6 and 7
// change nothing. Every request yields exactly one status result on the output
// channel (out_valid_o/out_ready_i): running, expired, active, elapsed time and
// the elapsed fraction in unsigned fixed point with FRACTION_BITS fraction bits.
// One request is worked at a time: it is captured, applied or phase-aligned, evaluated and,
// if needed, divided for the fraction; its result is loaded into the output register before
// the next request is taken. Alignment serves a restart of a running timer with a nonzero
// period, and the fraction a running timer with a nonzero period unless clamped at expiry;
// both passes use the shared one-bit-per-cycle restoring divider.
// A result waits in the output register while the receiver stalls; the next
// request is still accepted and is held before hand-off until that slot frees.
// Reset clears the counter, start time, period and running flag, and drops any
// pending result.
`include "assert_macros.svh"

module oneshot_periodic_timer
  import opt_pkg::*;
#(
  parameter int unsigned TIME_WIDTH    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [OpWidth-1:0]                   op_i,
  input  logic [DurationWidth-1:0]             duration_i,
  input  logic                                 clamp_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 running_o,
  output logic                                 expired_o,
  output logic                                 active_o,
  output logic [ElapsedWidth-1:0]              elapsed_o,
  output logic [FracIntBits+FRACTION_BITS-1:0] fraction_o
);

  opt_cmd_t cmd;
  opt_sts_t sts;

  opt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  opt_dp #(
    .TimeWidth    (TIME_WIDTH),
    .FractionBits (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .op_i       (op_i),
    .duration_i (duration_i),
    .clamp_i    (clamp_i),
    .running_o  (running_o),
    .expired_o  (expired_o),
    .active_o   (active_o),
    .elapsed_o  (elapsed_o),
    .fraction_o (fraction_o)
  );

  `OPT_ASSERT(a_idle_div_done, in_ready_o |-> sts.div_done, "divider busy while idle")
  `OPT_ASSERT(a_one_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o, "second request taken")
  `OPT_ASSERT(a_load_free, cmd.load_out |-> (!out_valid_o || out_ready_i), "result overwritten")
  `OPT_ASSERT(a_cmd_onehot, $onehot0(cmd), "conflicting datapath commands")

endmodule

// File: tb/sv/tb_oneshot_periodic_timer.sv
// Self-checking testbench for the one-shot/periodic timer with phase-aligned restart.
module tb_oneshot_periodic_timer;
  import opt_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned FracWidth  = FracIntBits + FracBits;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 100;

  localparam logic [OpWidth-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OpWidth-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic [FracWidth-1:0] FracOne = FracWidth'(1) << FracBits;

  typedef struct packed {
    logic [OpWidth-1:0]       op;
    logic [DurationWidth-1:0] duration;
    logic                     clamp;
  } timer_req_t;

  typedef struct packed {
    logic                    running;
    logic                    expired;
    logic                    active;
    logic [ElapsedWidth-1:0] elapsed;
    logic [FracWidth-1:0]    fraction;
  } timer_status_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [OpWidth-1:0]         op_i = OP_TICK;
  logic [DurationWidth-1:0]   duration_i = '0;
  logic                       clamp_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       running_o;
  logic                       expired_o;
  logic                       active_o;
  logic [ElapsedWidth-1:0]    elapsed_o;
  logic [FracWidth-1:0]       fraction_o;

  timer_req_t    pending_reqs[$];
  timer_status_t expected_status[$];
  timer_req_t    current_req;

  logic [ElapsedWidth-1:0] now_us = '0;
  logic [ElapsedWidth-1:0] start_us = '0;
  logic [ElapsedWidth-1:0] period_us = '0;
  logic                    timer_on = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  oneshot_periodic_timer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .duration_i  (duration_i),
    .clamp_i     (clamp_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .running_o   (running_o),
    .expired_o   (expired_o),
    .active_o    (active_o),
    .elapsed_o   (elapsed_o),
    .fraction_o  (fraction_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [FracWidth-1:0] elapsed_ratio(logic [ElapsedWidth-1:0] num,
                                                         logic [ElapsedWidth-1:0] den);
    logic [63:0] q;
    q = ({32'b0, num} << FracBits) / {32'b0, den};
    if (q > {{(64-FracWidth){1'b0}}, {FracWidth{1'b1}}}) begin
      return {FracWidth{1'b1}};
    end
    return q[FracWidth-1:0];
  endfunction

  // snap start time back to the last period boundary at or before now
  function automatic void align_start();
    logic [ElapsedWidth-1:0] el;
    if (period_us == '0) begin
      start_us = now_us;
    end else begin
      el = now_us - start_us;
      start_us = now_us - (el % period_us);
    end
  endfunction

  function automatic timer_status_t predict_status(timer_req_t req);
    timer_status_t st;
    logic [ElapsedWidth-1:0] el;
    st = '0;
    case (req.op)
      OP_TICK: begin
        now_us = now_us + ElapsedWidth'(1);
      end
      OP_START: begin
        start_us = now_us;
        period_us = req.duration;
        timer_on = 1'b1;
      end
      OP_RESET: begin
        start_us = '0;
        period_us = '0;
        timer_on = 1'b0;
      end
      OP_RESTART: begin
        if (!timer_on) begin
          start_us = now_us;
          period_us = '0;
          timer_on = 1'b1;
        end else begin
          align_start();
        end
      end
      OP_RESTART_DUR: begin
        if (!timer_on) begin
          start_us = now_us;
          timer_on = 1'b1;
        end else begin
          align_start();
        end
        period_us = req.duration;
      end
      OP_EXTEND: begin
        if (timer_on) period_us = period_us + req.duration;
      end
      default: ;
    endcase
    if (timer_on) begin
      el = now_us - start_us;
      st.running = 1'b1;
      st.expired = (period_us == '0) || (el >= period_us);
      st.active = !st.expired;
      st.elapsed = el;
      if (period_us != '0) begin
        st.fraction = (req.clamp && st.expired) ? FracOne : elapsed_ratio(el, period_us);
      end
    end
    return st;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  function automatic void push_req(logic [OpWidth-1:0] op, logic [DurationWidth-1:0] dur,
                                   logic clamp);
    timer_req_t req;
    req.op = op;
    req.duration = dur;
    req.clamp = clamp;
    pending_reqs.push_back(req);
  endfunction

  function automatic logic [DurationWidth-1:0] pick_duration();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 35) return $urandom_range(4, 1);
    if (sel < 75) return $urandom_range(64, 5);
    if (sel < 85) return $urandom_range(2000, 65);
    if (sel < 93) return $urandom;
    return {DurationWidth{1'b1}} - $urandom_range(3);
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned n;
    int unsigned sel;
    int unsigned burst;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        push_req(OP_START, pick_duration(), 1'($urandom_range(1)));
        n++;
      end else if (sel < 12) begin
        push_req(OP_RESET, $urandom, 1'($urandom_range(1)));
        n++;
      end else if (sel < 18) begin
        push_req(OP_RESTART, $urandom, 1'($urandom_range(1)));
        n++;
      end else if (sel < 24) begin
        push_req(OP_RESTART_DUR, pick_duration(), 1'($urandom_range(1)));
        n++;
      end else if (sel < 30) begin
        push_req(OP_EXTEND, pick_duration(), 1'($urandom_range(1)));
        n++;
      end else if (sel < 32) begin
        push_req($urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO, $urandom,
                 1'($urandom_range(1)));
      end else begin
        burst = ($urandom_range(19) == 0) ? $urandom_range(300, 200) : $urandom_range(12, 1);
        repeat (burst) push_req(OP_TICK, $urandom, 1'($urandom_range(1)));
        n += burst;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_status.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_status.push_back(predict_status(current_req));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          current_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          op_i <= current_req.op;
          duration_i <= current_req.duration;
          clamp_i <= current_req.clamp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    timer_status_t exp_st;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          $error("result with no request outstanding");
          mismatch_count++;
        end else begin
          exp_st = expected_status.pop_front();
          check_field("running", 32'(exp_st.running), 32'(running_o));
          check_field("expired", 32'(exp_st.expired), 32'(expired_o));
          check_field("active", 32'(exp_st.active), 32'(active_o));
          check_field("elapsed", exp_st.elapsed, elapsed_o);
          check_field("fraction", 32'(exp_st.fraction), 32'(fraction_o));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_req(OP_TICK, 32'h0, 1'b0);
    push_req(OP_EXTEND, 32'd5, 1'b1);
    push_req(OP_RESTART, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_TICK, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_RESTART, 32'h0, 1'b1);
    push_req(OP_RESET, 32'h0, 1'b0);
    push_req(OP_RESTART_DUR, 32'd3, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b1);
    push_req(OP_RESTART, 32'h0, 1'b0);
    push_req(OP_EXTEND, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b1);
    push_req(OP_RESTART_DUR, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_TICK, 32'h0, 1'b1);
    push_req(OP_START, 32'h0, 1'b1);
    push_req(OP_START, 32'd1, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b0);
    push_req(OP_TICK, 32'h0, 1'b0);
    push_req(OP_UNUSED_LO, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_UNUSED_HI, 32'h0, 1'b0);
    push_req(OP_EXTEND, 32'd7, 1'b0);
    push_req(OP_RESET, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_EXTEND, 32'd9, 1'b0);
    wait_drained();

    queue_random(500);
    wait_drained();

    send_idle_pct = 53;
    queue_random(500);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 53;
    queue_random(500);
    wait_drained();

    send_idle_pct = 15;
    recv_stall_pct = 15;
    queue_random(500);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
